>>> rtl/core/mlpsgd_pkg.sv
// ----------------------------------------------------------------------------
// mlpsgd_pkg
// Types and constants used by the output-layer trainer.
// ----------------------------------------------------------------------------
`default_nettype none

package mlpsgd_pkg;

    localparam logic [2:0] CMD_WRITE    = 3'd0;
    localparam logic [2:0] CMD_READ     = 3'd1;
    localparam logic [2:0] CMD_FEATURE  = 3'd2;
    localparam logic [2:0] CMD_CLASSIFY = 3'd3;
    localparam logic [2:0] CMD_TRAIN    = 3'd4;

    localparam logic [1:0] REG_CW0 = 2'd0;
    localparam logic [1:0] REG_CW1 = 2'd1;
    localparam logic [1:0] REG_CW2 = 2'd2;
    localparam logic [1:0] REG_LR  = 2'd3;

    localparam int          NCLASS    = 3;
    localparam logic [31:0] LOG2E_Q24 = 32'd24204406;
    localparam logic [31:0] LN2_Q24   = 32'd11629080;
    localparam logic [24:0] ONE_Q24   = 25'd16777216;
    localparam int          EXP_TERMS = 10;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_H_BIAS,
        ST_H_MAC,
        ST_H_STORE,
        ST_O_BIAS,
        ST_O_MAC,
        ST_O_STORE,
        ST_EXP_MUL,
        ST_EXP_FRAC,
        ST_EXP_G,
        ST_EXP_HORNER,
        ST_EXP_DIVK,
        ST_EXP_DONE,
        ST_DIV,
        ST_DELTA,
        ST_STEP,
        ST_UPD_RD,
        ST_UPD_MUL,
        ST_UPD_WR,
        ST_DONE
    } state_t;

    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        logic [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'h7fffffff;
        else if (v < -64'sd2147483648)
            r = 32'h80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/mlpsgd_ram.sv
// ----------------------------------------------------------------------------
// mlpsgd_ram
// Single-port generic RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module mlpsgd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

>>> rtl/core/mlp_output_layer_sgd_trainer_unit.sv
// ----------------------------------------------------------------------------
// mlp_output_layer_sgd_trainer_unit
// Two-layer perceptron with softmax and SGD on the output layer, one shared
// multiplier and one restoring divider under a sequencer.
// ----------------------------------------------------------------------------
// Write, read, load-feature and rejected requests: done in the cycle after the accepting edge.
// Classify and train run in sequence on the shared 33x33 multiply, the weight RAM port and a
// one-bit-a-cycle divider; train then updates the output-layer weights and biases. busy is high
// until done; the next request is accepted in the cycle after done. Reset returns control to
// idle and loads the config registers with their defaults only.
// Results cannot be stalled: done pulses for one cycle with the result.
`default_nettype none

module mlp_output_layer_sgd_trainer_unit
    import mlpsgd_pkg::*;
#(
    parameter int INPUT_SIZE  = 10,
    parameter int HIDDEN_SIZE = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [2:0]         cmd,
    input  wire logic [7:0]         index,
    input  wire logic signed [31:0] value,
    input  wire logic [1:0]         label,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    output logic                    done,
    output logic signed [31:0]      read_data,
    output logic [1:0]              predicted_class,
    output logic [24:0]             prob_zero,
    output logic [24:0]             prob_one,
    output logic [24:0]             prob_two,
    output logic                    bad_request
);

    localparam int OFS_B1 = INPUT_SIZE * HIDDEN_SIZE;
    localparam int OFS_W2 = OFS_B1 + HIDDEN_SIZE;
    localparam int OFS_B2 = OFS_W2 + HIDDEN_SIZE * NCLASS;
    localparam int NW     = OFS_B2 + NCLASS;
    localparam int AW     = (NW > 256) ? $clog2(NW) : 8;
    localparam int FW     = (INPUT_SIZE > 1) ? $clog2(INPUT_SIZE) : 1;
    localparam int HW     = (HIDDEN_SIZE > 1) ? $clog2(HIDDEN_SIZE) : 1;
    localparam int KW     = $clog2(INPUT_SIZE + 1);
    localparam int JW     = $clog2(HIDDEN_SIZE + 1);

    state_t state_reg, state_next;

    logic [31:0] cw_reg [NCLASS];
    logic [24:0] lr_reg;

    logic [2:0]  cmd_reg;
    logic [1:0]  label_reg;
    logic [KW-1:0] k_reg;
    logic [JW-1:0] j_reg;
    logic [1:0]  c_reg;
    logic [1:0]  phase_reg;
    logic signed [63:0] acc_reg;
    logic signed [31:0] hid [HIDDEN_SIZE];
    logic signed [31:0] feat [INPUT_SIZE];
    logic signed [31:0] logit [NCLASS];
    logic [24:0] e_reg [NCLASS];
    logic [24:0] prob_reg [NCLASS];
    logic signed [63:0] prod_reg;
    logic [63:0] u_reg;
    logic [4:0]  n_reg;
    logic [31:0] g_reg;
    logic [24:0] p_reg;
    logic [3:0]  term_reg;
    logic [49:0] dq_reg;
    logic [26:0] drem_reg;
    logic [5:0]  dcnt_reg;
    logic signed [31:0] s_reg [NCLASS];
    logic signed [31:0] wtmp_reg;
    logic        bad_reg;

    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [31:0]   ram_wdata;
    logic [31:0]   ram_rdata;

    mlpsgd_ram #(.WIDTH(32), .DEPTH(1 << AW)) u_wram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    assign mul_p = mul_a * mul_b;

    logic signed [31:0] mx;
    logic [26:0] esum;
    always_comb
    begin
        mx = logit[0];
        if (logit[1] > mx) mx = logit[1];
        if (logit[2] > mx) mx = logit[2];
        esum = {2'b0, e_reg[0]} + {2'b0, e_reg[1]} + {2'b0, e_reg[2]};
    end

    logic signed [32:0] dlt;
    assign dlt = 33'(mx) - 33'(logit[c_reg]);

    logic [26:0] dtrial;
    assign dtrial = {drem_reg[25:0], dq_reg[49]};

    logic [JW-1:0] upd_j;
    assign upd_j = j_reg;

    logic signed [31:0] upd_val;
    assign upd_val = sat32(64'(signed'(wtmp_reg)) - prod_reg);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = '0;
        ram_wdata = value;
        mul_a     = '0;
        mul_b     = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                ram_addr = AW'(index);
                ram_we   = start && (cmd == CMD_WRITE) && (32'(index) < NW);
            end
            ST_H_BIAS:  ram_addr = AW'(OFS_B1 + int'(j_reg));
            ST_H_MAC:
            begin
                ram_addr = AW'(int'(k_reg) * HIDDEN_SIZE + int'(j_reg));
                mul_a = 33'(signed'(ram_rdata));
                mul_b = 33'(feat[k_reg[FW-1:0] - FW'(1)]);
            end
            ST_O_BIAS:  ram_addr = AW'(OFS_B2 + int'(c_reg));
            ST_O_MAC:
            begin
                ram_addr = AW'(OFS_W2 + int'(j_reg) * NCLASS + int'(c_reg));
                mul_a = 33'(signed'(ram_rdata));
                mul_b = 33'(hid[j_reg[HW-1:0] - HW'(1)]);
            end
            ST_EXP_MUL:
            begin
                mul_a = dlt;
                mul_b = {1'b0, LOG2E_Q24};
            end
            ST_EXP_G:
            begin
                mul_a = {9'b0, u_reg[23:0]};
                mul_b = {1'b0, LN2_Q24};
            end
            ST_EXP_HORNER:
            begin
                mul_a = {1'b0, g_reg};
                mul_b = {8'b0, p_reg};
            end
            ST_DELTA:
            begin
                mul_a = {1'b0, cw_reg[label_reg]};
                mul_b = 33'(signed'({1'b0, prob_reg[c_reg]}))
                      - ((c_reg == label_reg) ? 33'(ONE_Q24) : 33'd0);
            end
            ST_STEP:
            begin
                mul_a = {8'b0, lr_reg};
                mul_b = 33'(wtmp_reg);
            end
            ST_UPD_RD, ST_UPD_WR:
            begin
                ram_addr = (upd_j == JW'(HIDDEN_SIZE))
                         ? AW'(OFS_B2 + int'(c_reg))
                         : AW'(OFS_W2 + int'(upd_j) * NCLASS + int'(c_reg));
                ram_we    = (state_reg == ST_UPD_WR);
                ram_wdata = upd_val;
            end
            ST_UPD_MUL:
            begin
                mul_a = 33'(s_reg[c_reg]);
                mul_b = 33'(hid[upd_j[HW-1:0]]);
            end
            default: ;
        endcase
    end

    logic [65:0] u_full;
    assign u_full = unsigned'(mul_p);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (start)
                begin
                    if ((cmd == CMD_CLASSIFY) || (cmd == CMD_TRAIN && label != 2'd3))
                        state_next = ST_H_BIAS;
                    else
                        state_next = ST_DONE;
                end
            ST_H_BIAS:  state_next = ST_H_MAC;
            ST_H_MAC:
                if (int'(k_reg) == INPUT_SIZE) state_next = ST_H_STORE;
            ST_H_STORE:
                state_next = (int'(j_reg) == HIDDEN_SIZE - 1) ? ST_O_BIAS : ST_H_BIAS;
            ST_O_BIAS:  state_next = ST_O_MAC;
            ST_O_MAC:
                if (int'(j_reg) == HIDDEN_SIZE) state_next = ST_O_STORE;
            ST_O_STORE:
                state_next = (c_reg == 2'd2) ? ST_EXP_MUL : ST_O_BIAS;
            ST_EXP_MUL:  state_next = ST_EXP_FRAC;
            ST_EXP_FRAC: state_next = ST_EXP_G;
            ST_EXP_G:    state_next = ST_EXP_HORNER;
            ST_EXP_HORNER: state_next = ST_EXP_DIVK;
            ST_EXP_DIVK:
                if (dcnt_reg == 6'd0)
                    state_next = (term_reg == 4'd1) ? ST_EXP_DONE : ST_EXP_HORNER;
            ST_EXP_DONE:
                state_next = (c_reg == 2'd2) ? ST_DIV : ST_EXP_MUL;
            ST_DIV:
                if (dcnt_reg == 6'd0 && c_reg == 2'd2 && phase_reg == 2'd1)
                    state_next = (cmd_reg == CMD_TRAIN) ? ST_DELTA : ST_DONE;
            ST_DELTA:   state_next = ST_STEP;
            ST_STEP:    state_next = (c_reg == 2'd2) ? ST_UPD_RD : ST_DELTA;
            ST_UPD_RD:  state_next = ST_UPD_MUL;
            ST_UPD_MUL: state_next = ST_UPD_WR;
            ST_UPD_WR:
                if (int'(j_reg) == HIDDEN_SIZE && c_reg == 2'd2)
                    state_next = ST_DONE;
                else
                    state_next = ST_UPD_RD;
            ST_DONE:    state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        busy = (state_reg != ST_IDLE);
        done = (state_reg == ST_DONE);
        read_data       = (cmd_reg == CMD_READ && !bad_reg) ? signed'(ram_rdata) : 32'sd0;
        bad_request     = bad_reg;
        prob_zero       = prob_reg[0];
        prob_one        = prob_reg[1];
        prob_two        = prob_reg[2];
        predicted_class = 2'd0;
        if (prob_reg[1] > prob_reg[0]) predicted_class = 2'd1;
        if (prob_reg[2] > prob_reg[predicted_class]) predicted_class = 2'd2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cw_reg[0] <= 32'd16777216;
            cw_reg[1] <= 32'd16777216;
            cw_reg[2] <= 32'd16777216;
            lr_reg    <= 25'd16777;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_CW0: cw_reg[0] <= cfg_data;
                    REG_CW1: cw_reg[1] <= cfg_data;
                    REG_CW2: cw_reg[2] <= cfg_data;
                    REG_LR:  lr_reg    <= cfg_data[24:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd_reg   <= cmd;
                label_reg <= label;
                bad_reg   <= 1'b0;
                j_reg     <= '0;
                c_reg     <= '0;
                for (int i = 0; i < NCLASS; i++) prob_reg[i] <= '0;
                if (start)
                begin
                    if (cmd == CMD_WRITE || cmd == CMD_READ)
                        bad_reg <= (32'(index) >= NW);
                    else if (cmd == CMD_FEATURE)
                    begin
                        if (32'(index) >= INPUT_SIZE)
                            bad_reg <= 1'b1;
                        else
                            feat[index[FW-1:0]] <= value;
                    end
                    else if (cmd == CMD_TRAIN)
                        bad_reg <= (label == 2'd3);
                    else if (cmd != CMD_CLASSIFY)
                        bad_reg <= 1'b1;
                end
            end
            ST_H_BIAS:
                k_reg <= '0;
            ST_H_MAC:
            begin
                if (k_reg == '0)
                    acc_reg <= 64'(signed'(ram_rdata));
                else
                    acc_reg <= acc_reg + 64'(mul_p >>> 24);
                k_reg <= k_reg + KW'(1);
            end
            ST_H_STORE:
            begin
                hid[j_reg[HW-1:0]] <= acc_reg[63] ? 32'sd0 : sat32(acc_reg);
                j_reg <= (int'(j_reg) == HIDDEN_SIZE - 1) ? '0 : j_reg + JW'(1);
            end
            ST_O_BIAS:
                j_reg <= '0;
            ST_O_MAC:
            begin
                if (j_reg == '0)
                    acc_reg <= 64'(signed'(ram_rdata));
                else
                    acc_reg <= acc_reg + 64'(mul_p >>> 24);
                j_reg <= j_reg + JW'(1);
            end
            ST_O_STORE:
            begin
                logit[c_reg] <= sat32(acc_reg);
                c_reg <= (c_reg == 2'd2) ? 2'd0 : c_reg + 2'd1;
            end
            ST_EXP_MUL:
                u_reg <= u_full[63:0] >> 24;
            ST_EXP_FRAC:
            begin
                n_reg <= (u_reg[63:24] >= 40'd25) ? 5'd25 : u_reg[28:24];
                p_reg <= ONE_Q24;
                term_reg <= 4'(EXP_TERMS);
            end
            ST_EXP_G:
                g_reg <= u_full[55:24];
            ST_EXP_HORNER:
            begin
                dq_reg   <= {u_full[49:24], 24'b0};
                drem_reg <= '0;
                dcnt_reg <= 6'd26;
            end
            ST_EXP_DIVK:
            begin
                if (dcnt_reg == 6'd0)
                begin
                    p_reg    <= ONE_Q24 - dq_reg[24:0];
                    term_reg <= term_reg - 4'd1;
                end
                else
                begin
                    dq_reg <= {dq_reg[48:0], (dtrial >= 27'(term_reg))};
                    drem_reg <= (dtrial >= 27'(term_reg)) ? dtrial - 27'(term_reg)
                                                          : dtrial;
                    dcnt_reg <= dcnt_reg - 6'd1;
                end
            end
            ST_EXP_DONE:
            begin
                e_reg[c_reg] <= (n_reg == 5'd25) ? 25'd0 : p_reg >> n_reg;
                c_reg     <= (c_reg == 2'd2) ? 2'd0 : c_reg + 2'd1;
                phase_reg <= 2'd0;
            end
            ST_DIV:
            begin
                if (phase_reg == 2'd0)
                begin
                    dq_reg    <= {e_reg[c_reg], 25'b0};
                    drem_reg  <= '0;
                    dcnt_reg  <= 6'd50;
                    phase_reg <= 2'd1;
                end
                else if (dcnt_reg == 6'd0)
                begin
                    prob_reg[c_reg] <= dq_reg[25:1];
                    c_reg     <= (c_reg == 2'd2) ? 2'd0 : c_reg + 2'd1;
                    phase_reg <= 2'd0;
                end
                else
                begin
                    dq_reg <= {dq_reg[48:0], (dtrial >= esum)};
                    drem_reg <= (dtrial >= esum) ? dtrial - esum : dtrial;
                    dcnt_reg <= dcnt_reg - 6'd1;
                end
            end
            ST_DELTA:
                wtmp_reg <= sat32(64'(mul_p >>> 24));
            ST_STEP:
            begin
                s_reg[c_reg] <= 32'(mul_p >>> 24);
                c_reg <= (c_reg == 2'd2) ? 2'd0 : c_reg + 2'd1;
                j_reg <= '0;
            end
            ST_UPD_MUL:
                prod_reg <= (upd_j == JW'(HIDDEN_SIZE)) ? 64'(s_reg[c_reg])
                                                         : 64'(mul_p >>> 24);
            ST_UPD_WR:
            begin
                if (int'(j_reg) == HIDDEN_SIZE)
                begin
                    j_reg <= '0;
                    c_reg <= c_reg + 2'd1;
                end
                else
                    j_reg <= j_reg + JW'(1);
            end
            default: ;
        endcase
        if (state_reg == ST_UPD_MUL)
            wtmp_reg <= ram_rdata;
    end

endmodule

`default_nettype wire
